### rtl/irdi_pkg.sv
// Package for the IR sample to distance converter.
// Holds the word types and operation codes; no dependencies.
package irdi_pkg;

   localparam int READING_W   = 10;
   localparam int DISTANCE_W  = 8;
   localparam int INDEX_W     = 4;
   localparam int SENSOR_W    = 3;
   localparam int MASK_W      = 8;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_CONVERT = 1'b1
   } op_type;

   // how a convert word resolves against the table
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_FIRST   = 2'd1,
      KIND_LAST    = 2'd2,
      KIND_SEGMENT = 2'd3
   } kind_type;

   typedef struct packed {
      op_type                 op;
      logic [INDEX_W-1:0]     point_index;
      logic [READING_W-1:0]   point_reading;
      logic [DISTANCE_W-1:0]  point_distance;
      logic [SENSOR_W-1:0]    sensor_index;
      logic [READING_W-1:0]   sample_value;
   } req_type;

   typedef struct packed {
      logic [DISTANCE_W-1:0]  distance_cm;
      logic [SENSOR_W-1:0]    sensor_echo;
   } rsp_type;

endpackage

### rtl/ir_sample_to_distance_interp.sv
// IR sample to distance converter, piecewise linear over a loaded table.
// Accepts one word per cycle while the output is not stalled by rsp_ready.
// The segment search compares all points in parallel; the divider has one
// stage per quotient bit. Load words write the table at the first stage.
// Reset (synchronous): clears valid bits and the enable mask; table undefined.
module ir_sample_to_distance_interp
   import irdi_pkg::*;
#(
   parameter int POINTS      = 12,
   parameter int SENSORS     = 8,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [MASK_W-1:0]   csr_data
);

   localparam int PI_W  = $clog2(POINTS);
   localparam int NUM_W = SAMPLE_BITS + DISTANCE_W;
   localparam int SIDE_W = 2 + 1 + DISTANCE_W + SENSOR_W;

   logic [MASK_W-1:0]      mask_ff;
   logic [SAMPLE_BITS-1:0] rd_mem [POINTS];
   logic [DISTANCE_W-1:0]  ds_mem [POINTS];

   logic advance;
   logic out_valid;
   rsp_type out_ff;
   logic out_full_ff;
   assign advance   = !out_full_ff || rsp_ready;
   assign req_ready = advance;

   logic [SAMPLE_BITS-1:0] sample;
   assign sample = SAMPLE_BITS'(req_data.sample_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_write) begin
         mask_ff <= csr_data;
      end
      if (req_valid && req_ready && req_data.op == OP_LOAD
          && 32'(req_data.point_index) < POINTS) begin
         rd_mem[PI_W'(req_data.point_index)] <=
            SAMPLE_BITS'(req_data.point_reading);
         ds_mem[PI_W'(req_data.point_index)] <= req_data.point_distance;
      end
   end

   // stage 1: compare against every point, pick last matching segment
   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [SENSOR_W-1:0]    s1_sensor_ff;
   logic                   s1_en_ff;
   kind_type               s1_kind_ff;
   logic [PI_W-1:0]        s1_seg_ff;
   kind_type               kind_in;
   logic [PI_W-1:0]        seg_in;
   logic                   en_in;

   always_comb begin
      kind_in = KIND_NONE;
      seg_in  = '0;
      for (int i = 0; i < POINTS-1; i++) begin
         if (sample < rd_mem[i] && sample >= rd_mem[i+1]) begin
            kind_in = KIND_SEGMENT;
            seg_in  = PI_W'(i);
         end
      end
      if (sample < rd_mem[POINTS-1]) kind_in = KIND_LAST;
      if (sample >= rd_mem[0])       kind_in = KIND_FIRST;
      en_in = 32'(req_data.sensor_index) < SENSORS
              && mask_ff[req_data.sensor_index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid && req_data.op == OP_CONVERT;
      end
      if (advance) begin
         s1_sample_ff <= sample;
         s1_sensor_ff <= req_data.sensor_index;
         s1_en_ff     <= en_in;
         s1_kind_ff   <= kind_in;
         s1_seg_ff    <= seg_in;
      end
   end

   // stage 2: fetch segment endpoints, form magnitudes
   logic                   s2_valid_ff;
   logic [SENSOR_W-1:0]    s2_sensor_ff;
   logic                   s2_en_ff;
   kind_type               s2_kind_ff;
   logic [SAMPLE_BITS-1:0] s2_dr_ff;     // r[i] - sample
   logic [SAMPLE_BITS-1:0] s2_den_ff;    // r[i] - r[i+1]
   logic [DISTANCE_W-1:0]  s2_dd_ff;     // |d[i+1] - d[i]|
   logic                   s2_neg_ff;
   logic [DISTANCE_W-1:0]  s2_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_sensor_ff <= s1_sensor_ff;
         s2_en_ff     <= s1_en_ff;
         s2_kind_ff   <= s1_kind_ff;
         s2_dr_ff     <= rd_mem[s1_seg_ff] - s1_sample_ff;
         s2_den_ff    <= rd_mem[s1_seg_ff] - rd_mem[PI_W'(s1_seg_ff + 1'b1)];
         s2_neg_ff    <= ds_mem[PI_W'(s1_seg_ff + 1'b1)] < ds_mem[s1_seg_ff];
         s2_dd_ff     <= (ds_mem[PI_W'(s1_seg_ff + 1'b1)] < ds_mem[s1_seg_ff])
                         ? ds_mem[s1_seg_ff] - ds_mem[PI_W'(s1_seg_ff + 1'b1)]
                         : ds_mem[PI_W'(s1_seg_ff + 1'b1)] - ds_mem[s1_seg_ff];
         case (s1_kind_ff)
            KIND_FIRST: s2_base_ff <= ds_mem[0];
            KIND_LAST:  s2_base_ff <= ds_mem[POINTS-1];
            default:    s2_base_ff <= ds_mem[s1_seg_ff];
         endcase
      end
   end

   // stage 3: multiply; quotient sign follows d[i+1]-d[i] since (s-r)/(rb-ra) = dr/den
   logic                   s3_valid_ff;
   logic [NUM_W-1:0]       s3_num_ff;
   logic [SAMPLE_BITS-1:0] s3_den_ff;
   logic [SIDE_W-1:0]      s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_num_ff  <= NUM_W'(s2_dr_ff) * NUM_W'(s2_dd_ff);
         s3_den_ff  <= (s2_kind_ff == KIND_SEGMENT) ? s2_den_ff : SAMPLE_BITS'(1);
         s3_side_ff <= {s2_kind_ff, s2_neg_ff, s2_base_ff, s2_sensor_ff} &
                       {SIDE_W{1'b1}} & ({SIDE_W{1'b1}} ^ {SIDE_W{1'b0}})
                       & {{(SIDE_W-SENSOR_W){s2_en_ff}}, {SENSOR_W{1'b1}}};
      end
   end

   logic              dv_valid;
   logic [NUM_W-1:0]  dv_quot;
   logic [SIDE_W-1:0] dv_side;

   irdi_divider #(.NUM_W(NUM_W), .DEN_W(SAMPLE_BITS), .SIDE_W(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   assign out_valid = dv_valid;

   // final: apply sign, clamp to 0..255; disabled words carry kind none
   kind_type              f_kind;
   logic                  f_neg;
   logic [DISTANCE_W-1:0] f_base;
   logic [NUM_W+1:0]      f_sum;
   logic [DISTANCE_W-1:0] f_dist;

   always_comb begin
      f_kind = kind_type'(dv_side[SIDE_W-1 -: 2]);
      f_neg  = dv_side[DISTANCE_W+SENSOR_W];
      f_base = dv_side[SENSOR_W +: DISTANCE_W];
      f_sum  = f_neg ? (NUM_W+2)'(f_base) - (NUM_W+2)'(dv_quot)
                     : (NUM_W+2)'(f_base) + (NUM_W+2)'(dv_quot);
      case (f_kind) inside
         KIND_FIRST, KIND_LAST: f_dist = f_base;
         KIND_SEGMENT: begin
            if (f_sum[NUM_W+1])             f_dist = '0;
            else if (f_sum > (NUM_W+2)'(255)) f_dist = '1;
            else                            f_dist = f_sum[DISTANCE_W-1:0];
         end
         default:    f_dist = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (advance) begin
         out_full_ff <= out_valid;
      end
      if (advance) begin
         out_ff.distance_cm <= f_dist;
         out_ff.sensor_echo <= dv_side[SENSOR_W-1:0];
      end
   end

   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_LOAD |=> !s1_valid_ff)
      else $error("load word entered convert pipe");

endmodule

### rtl/irdi_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Carries a side word alongside; imports irdi_pkg but takes its widths from parameters.
module irdi_divider
   import irdi_pkg::*;
#(
   parameter int NUM_W  = 18,
   parameter int DEN_W  = 10,
   parameter int SIDE_W = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [1:NUM_W];
   logic [NUM_W-1:0]  quot_ff  [1:NUM_W];
   logic [DEN_W:0]    rem_ff   [1:NUM_W];
   logic [NUM_W-1:0]  num_ff   [1:NUM_W];
   logic [DEN_W-1:0]  den_ff   [1:NUM_W];
   logic [SIDE_W-1:0] side_ff  [1:NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              cur_valid;
      logic [NUM_W-1:0]  cur_quot;
      logic [DEN_W:0]    cur_rem;
      logic [NUM_W-1:0]  cur_num;
      logic [DEN_W-1:0]  cur_den;
      logic [SIDE_W-1:0] cur_side;
      logic [DEN_W+1:0]  trial;
      logic [DEN_W:0]    rem_in;
      logic              bit_in;
      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_quot  = '0;
         assign cur_rem   = '0;
         assign cur_num   = in_num;
         assign cur_den   = in_den;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k];
         assign cur_quot  = quot_ff[k];
         assign cur_rem   = rem_ff[k];
         assign cur_num   = num_ff[k];
         assign cur_den   = den_ff[k];
         assign cur_side  = side_ff[k];
      end
      always_comb begin
         trial  = {cur_rem, cur_num[NUM_W-1-k]};
         bit_in = trial >= {2'b00, cur_den};
         rem_in = bit_in ? (DEN_W+1)'(trial - {2'b00, cur_den}) : trial[DEN_W:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= cur_valid;
         end
         if (advance) begin
            quot_ff[k+1] <= cur_quot | (NUM_W'(bit_in) << (NUM_W-1-k));
            rem_ff[k+1]  <= rem_in;
            num_ff[k+1]  <= cur_num;
            den_ff[k+1]  <= cur_den;
            side_ff[k+1] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quot  = quot_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];

endmodule
